@@ rtl/rcp_pkg.sv @@
// Shared types and constants for the right corner pooling block.
// Depends on nothing; rcp_csr and right_corner_pool refer to it by scoped names.
`default_nettype none

package rcp_pkg;

   localparam int MAX_ROW_WIDTH = 64;
   localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
   localparam int WIDTH_W       = COL_W + 1;
   localparam int VALUE_W       = 16;
   localparam int ACC_W         = 24;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   // Register indexes (byte address = 4 * index)
   localparam logic REG_MODE      = 1'b0;
   localparam logic REG_ROW_WIDTH = 1'b1;

   localparam logic MODE_FORWARD  = 1'b0;
   localparam logic MODE_BACKWARD = 1'b1;

   localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(MAX_ROW_WIDTH);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] grad;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] result;
      logic                    last_in_row;
   } rsp_type;

   typedef struct packed {
      logic               mode;
      logic [WIDTH_W-1:0] width;   // effective row width, 1..MAX_ROW_WIDTH
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_ACC       = 4'b0010,
      ST_DRAIN_RD  = 4'b0100,
      ST_DRAIN_OUT = 4'b1000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/rcp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rcp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/rcp_csr.sv @@
// Configuration registers (mode, row width) behind an APB-style port.
// Depends on rcp_pkg.
`default_nettype none

module rcp_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rcp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [rcp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [rcp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output rcp_pkg::cfg_type                      cfg
);

   logic                          mode_ff, mode_in;
   logic [rcp_pkg::WIDTH_W-1:0]   row_width_ff, row_width_in;
   logic                          wr_hit;
   logic                          reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mode_in      = mode_ff;
      row_width_in = row_width_ff;
      if (wr_hit) begin
         unique case (reg_sel)
            rcp_pkg::REG_MODE: begin
               mode_in = csr_pwdata[0];
            end
            rcp_pkg::REG_ROW_WIDTH: begin
               row_width_in = csr_pwdata[rcp_pkg::WIDTH_W-1:0];
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= rcp_pkg::MODE_FORWARD;
         row_width_ff <= rcp_pkg::ROW_WIDTH_RESET;
      end else begin
         mode_ff      <= mode_in;
         row_width_ff <= row_width_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         rcp_pkg::REG_MODE: begin
            csr_prdata[0] = mode_ff;
         end
         rcp_pkg::REG_ROW_WIDTH: begin
            csr_prdata[rcp_pkg::WIDTH_W-1:0] = row_width_ff;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // clamp width: zero acts as one, anything above the maximum as the maximum
   always_comb begin
      cfg.mode = mode_ff;
      if (row_width_ff == '0) begin
         cfg.width = rcp_pkg::WIDTH_W'(1);
      end else if (row_width_ff > rcp_pkg::ROW_WIDTH_RESET) begin
         cfg.width = rcp_pkg::ROW_WIDTH_RESET;
      end else begin
         cfg.width = row_width_ff;
      end
   end

endmodule

`default_nettype wire

@@ rtl/right_corner_pool.sv @@
// Right corner pooling over one feature-map row, signed Q8.8 fixed point.
// Depends on rcp_pkg, rcp_csr and rcp_ram.
//
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one column element
//   per request: value and grad. rsp channel (rsp_valid / rsp_stall /
//   rsp_data) returns result and last_in_row. csr_* is an APB-style port:
//   mode at byte address 0, row_width at byte address 4.
//   Forward mode: every request yields the running row maximum, registered
//   on acceptance; one request per cycle is sustained while rsp_stall is low.
//   Backward mode: each request does a read-modify-write of the gradient
//   accumulator at the argmax column in the accumulator RAM (read, then
//   write-back), and no new request is taken until the write-back is done.
//   The request that closes a row then drains row_width results, each by a
//   RAM read, then an output load; no request is taken during the drain.
//   The RAM has one read port, one write port and registered read data.
//   Reset clears the running maximum, the column counter and the per-column
//   valid bits, so every accumulator reads as zero; the same valid bits are
//   dropped at each row end, so no RAM clearing pass is needed.
//   When rsp_stall is high the output register holds its result and
//   req_stall rises until the result is taken.
`default_nettype none

module right_corner_pool (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire rcp_pkg::req_type                 req_data,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output rcp_pkg::rsp_type                      rsp_data,
   // configuration
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rcp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [rcp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [rcp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   localparam int COL_W   = rcp_pkg::COL_W;
   localparam int WIDTH_W = rcp_pkg::WIDTH_W;
   localparam int ACC_W   = rcp_pkg::ACC_W;
   localparam int VALUE_W = rcp_pkg::VALUE_W;
   localparam int MAXW    = rcp_pkg::MAX_ROW_WIDTH;

   rcp_pkg::cfg_type cfg;

   rcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // control state
   rcp_pkg::state_type          state_ff, state_in;
   logic signed [VALUE_W-1:0]   max_ff, max_in;
   logic [COL_W-1:0]            arg_ff, arg_in;
   logic [WIDTH_W-1:0]          col_ff, col_in;
   logic [MAXW-1:0]             acc_valid_ff, acc_valid_in;
   logic [COL_W-1:0]            drain_ff, drain_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   // payload
   rcp_pkg::rsp_type            rsp_ff, rsp_in;
   logic signed [VALUE_W-1:0]   grad_ff, grad_in;
   logic                        last_ff, last_in;

   // RAM ports
   logic                        ram_wr_en;
   logic signed [ACC_W-1:0]     ram_wr_data;
   logic                        ram_rd_en;
   logic [COL_W-1:0]            ram_rd_addr;
   logic [ACC_W-1:0]            ram_rd_data;

   logic                        out_free;
   logic                        accept;
   logic                        row_last;
   logic                        take_new;
   logic signed [VALUE_W-1:0]   new_max;
   logic [COL_W-1:0]            new_arg;
   logic signed [ACC_W-1:0]     acc_old;
   logic signed [ACC_W:0]       acc_sum;
   logic signed [ACC_W-1:0]     drain_val;
   logic                        drain_last;

   rcp_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MAXW)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (arg_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register is free when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == rcp_pkg::ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // max tracking: first column always takes the value, later only if greater
   assign row_last = (col_ff + WIDTH_W'(1)) >= cfg.width;
   assign take_new = (col_ff == '0) || (req_data.value > max_ff);
   assign new_max  = take_new ? req_data.value : max_ff;
   assign new_arg  = take_new ? col_ff[COL_W-1:0] : arg_ff;

   // accumulate: an entry without its valid bit reads as zero
   assign acc_old = acc_valid_ff[arg_ff] ? $signed(ram_rd_data) : '0;
   assign acc_sum = (ACC_W+1)'(acc_old) + (ACC_W+1)'(grad_ff);

   always_comb begin
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         ram_wr_data = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         ram_wr_data = acc_sum[ACC_W-1:0];
      end
   end

   assign drain_val  = acc_valid_ff[drain_ff] ? $signed(ram_rd_data) : '0;
   assign drain_last = (WIDTH_W'(drain_ff) + WIDTH_W'(1)) == cfg.width;

   always_comb begin
      state_in     = state_ff;
      max_in       = max_ff;
      arg_in       = arg_ff;
      col_in       = col_ff;
      acc_valid_in = acc_valid_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      grad_in      = grad_ff;
      last_in      = last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = new_arg;

      unique case (state_ff)
         rcp_pkg::ST_IDLE: begin
            if (accept) begin
               max_in  = new_max;
               arg_in  = new_arg;
               col_in  = row_last ? '0 : col_ff + WIDTH_W'(1);
               grad_in = req_data.grad;
               last_in = row_last;
               if (cfg.mode == rcp_pkg::MODE_FORWARD) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.result      = ACC_W'(new_max);
                  rsp_in.last_in_row = row_last;
                  // forward row end drops any gathered gradients
                  if (row_last) begin
                     acc_valid_in = '0;
                  end
               end else begin
                  // fetch the argmax accumulator
                  ram_rd_en = 1'b1;
                  state_in  = rcp_pkg::ST_ACC;
               end
            end
         end
         rcp_pkg::ST_ACC: begin
            ram_wr_en            = 1'b1;
            acc_valid_in[arg_ff] = 1'b1;
            if (last_ff) begin
               drain_in = '0;
               state_in = rcp_pkg::ST_DRAIN_RD;
            end else begin
               state_in = rcp_pkg::ST_IDLE;
            end
         end
         rcp_pkg::ST_DRAIN_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = drain_ff;
            state_in    = rcp_pkg::ST_DRAIN_OUT;
         end
         rcp_pkg::ST_DRAIN_OUT: begin
            // read data holds until the output register can take it
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result      = drain_val;
               rsp_in.last_in_row = drain_last;
               if (drain_last) begin
                  acc_valid_in = '0;
                  state_in     = rcp_pkg::ST_IDLE;
               end else begin
                  drain_in = drain_ff + COL_W'(1);
                  state_in = rcp_pkg::ST_DRAIN_RD;
               end
            end
         end
         default: begin
            state_in = rcp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcp_pkg::ST_IDLE;
         max_ff       <= '0;
         arg_ff       <= '0;
         col_ff       <= '0;
         acc_valid_ff <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         arg_ff       <= arg_in;
         col_ff       <= col_in;
         acc_valid_ff <= acc_valid_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      grad_ff <= grad_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire
